>>> hdl/prs_pkg.sv
// ============================================================================
// prs_pkg - shared types and constants for the power rail sequencer
// Command codes, step kinds, sequencer modes and the result beat layout.
// ============================================================================
package prs_pkg;

    // command codes carried in s_axis_tuser
    localparam logic [2:0] CMD_TICK       = 3'd0;
    localparam logic [2:0] CMD_POWER_UP   = 3'd1;
    localparam logic [2:0] CMD_POWER_DOWN = 3'd2;
    localparam logic [2:0] CMD_LOAD       = 3'd3;
    localparam logic [2:0] CMD_ACT_DONE   = 3'd4;

    // step kinds
    localparam logic [1:0] KIND_DRIVE  = 2'd0;
    localparam logic [1:0] KIND_WAIT   = 2'd1;
    localparam logic [1:0] KIND_ACTION = 2'd2;

    // number of sense inputs that are wired
    localparam int N_SENSES = 16;

    // fixed field widths
    localparam int CMD_W     = 3;
    localparam int SENSE_W   = 16;
    localparam int STEPCNT_W = 6;
    localparam int ENOUT_W   = 16;
    localparam int HDR_W     = 14;
    localparam int IN_DATA_W = 56;
    localparam int RES_W     = 32;

    // sequencer modes, one-hot
    typedef enum logic [7:0] {
        M_IDLE     = 8'b0000_0001,
        M_UP       = 8'b0000_0010,
        M_UP_ACT   = 8'b0000_0100,
        M_UP_DELAY = 8'b0000_1000,
        M_ROLL     = 8'b0001_0000,
        M_DOWN     = 8'b0010_0000,
        M_ROLL_ACT = 8'b0100_0000,
        M_DOWN_ACT = 8'b1000_0000
    } mode_t;

    // fixed part of a table step, kind in the lowest bits
    typedef struct packed {
        logic [3:0] off_action;
        logic [3:0] on_action;
        logic [3:0] bit_idx;
        logic [1:0] kind;
    } step_hdr_t;

    // result beat, last field in the lowest bits
    typedef struct packed {
        logic       pad;
        logic [5:0] current_step;
        logic       fault;
        logic       powered;
        logic       busy_res;
        logic       action_is_off;
        logic [3:0] action_code;
        logic       action_valid;
        logic [15:0] enable_bits;
    } result_t;

endpackage

>>> hdl/prs_step_table.sv
// ============================================================================
// prs_step_table - generic single-port-write RAM with registered read
// One write port and one read port; the read data is registered and a write
// to the address being read returns the new data. Entries have no reset.
// ============================================================================
module prs_step_table #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 30
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_idx,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_idx,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_idx] <= wr_data;
        end
    end

    // registered read port, write-first on an address match
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == rd_idx))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem_reg[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/prs_out_buf.sv
// ============================================================================
// prs_out_buf - result register with skid stage
// Holds up to two result beats so the input side can still push a beat while
// the downstream side stalls.
// ============================================================================
module prs_out_buf #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data,
    input  logic             out_ready
);

    logic             main_valid_reg;
    logic [WIDTH-1:0] main_data_reg;
    logic             skid_valid_reg;
    logic [WIDTH-1:0] skid_data_reg;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_data_reg;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || out_ready)
        begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push && !skid_valid_reg)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

>>> hdl/power_rail_sequencer.sv
// ============================================================================
// power_rail_sequencer - power-up / power-down sequencer with rollback
// Runs a loaded step table forward on power-up and backward on power-down
// or after a failed action; each command beat moves the sequence at most one step.
// ============================================================================
//
//  channel   direction  handshake                 contents
//  s_axis    in         tvalid/tready             tuser cmd, tdata step/sense
//  m_axis    out        tvalid/tready             tdata status result
//  cfg       in         cfg_we (no wait)          step_count
//
//  Every accepted beat yields exactly one result beat.
//  One beat per cycle while s_axis_tready is high: the table is read ahead
//  at the step the next beat works on, so each update is one pass from the
//  state and table read registers to the result register.
//  The result register plus a skid stage let an input beat be taken while
//  the output stalls; s_axis_tready drops only while both stages are full.
//  Reset clears the sequencer state and sets step_count to 17; the table
//  itself is not cleared.
//
module power_rail_sequencer #(
    parameter int MAX_STEPS  = 32,
    parameter int N_ENABLES  = 16,
    parameter int DELAY_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // slave side
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: sense_bits[15:0], action_failed[16], load_index[21:17],
    //        load_kind[23:22], load_bit[27:24], load_on_action[31:28],
    //        load_off_action[35:32], load_delay[51:36], zero pad
    input  logic [prs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: cmd[2:0]
    input  logic [prs_pkg::CMD_W-1:0]       s_axis_tuser,
    // master side
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: enable_bits[15:0], action_valid[16], action_code[20:17],
    //        action_is_off[21], busy_res[22], powered[23], fault[24],
    //        current_step[30:25], zero pad
    output logic [prs_pkg::RES_W-1:0]       m_axis_tdata,
    // configuration
    input  logic                            cfg_we,
    input  logic [prs_pkg::STEPCNT_W-1:0]   cfg_wdata
);

    import prs_pkg::*;

    localparam int PW     = $clog2(MAX_STEPS + 1);
    localparam int IW     = $clog2(MAX_STEPS);
    localparam int STEP_W = HDR_W + DELAY_BITS;

    // input unpacking
    logic [2:0]            cmd;
    logic [SENSE_W-1:0]    sense_bits;
    logic                  action_failed;
    logic [4:0]            load_index;
    step_hdr_t             load_hdr;
    logic [15:0]           load_delay;
    logic                  s_fire;

    assign cmd           = s_axis_tuser;
    assign sense_bits    = s_axis_tdata[15:0];
    assign action_failed = s_axis_tdata[16];
    assign load_index    = s_axis_tdata[21:17];
    assign load_hdr      = step_hdr_t'(s_axis_tdata[35:22]);
    assign load_delay    = s_axis_tdata[51:36];
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // state
    logic [STEPCNT_W-1:0]  step_count_reg;
    mode_t                 mode_reg, mode_next;
    logic [PW-1:0]         step_ptr_reg, step_ptr_next;
    logic [DELAY_BITS-1:0] delay_reg, delay_next;
    logic [N_ENABLES-1:0]  enable_reg, enable_next;
    logic                  fault_reg, fault_next;
    logic                  powered_reg, powered_next;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= STEPCNT_W'(17);
        end
        else if (cfg_we)
        begin
            step_count_reg <= cfg_wdata;
        end
    end

    // steps in use, clamped to the table depth
    logic [PW-1:0] used_steps;
    assign used_steps = (int'(step_count_reg) > MAX_STEPS) ? PW'(MAX_STEPS)
                                                            : PW'(step_count_reg);

    // active step: step_ptr going up, step_ptr - 1 going down
    logic          undo_mode;
    logic [PW-1:0] rd_ptr;
    logic          rd_ok;
    logic [STEP_W-1:0] rd_raw, step_word, load_word;
    logic          load_ok, load_hit;
    logic          undo_next;
    logic [PW-1:0] rd_ptr_next;

    assign undo_mode = (mode_reg == M_ROLL) || (mode_reg == M_DOWN) ||
                       (mode_reg == M_ROLL_ACT) || (mode_reg == M_DOWN_ACT);
    assign rd_ptr    = undo_mode ? (step_ptr_reg - PW'(1)) : step_ptr_reg;
    assign rd_ok     = (int'(rd_ptr) < MAX_STEPS) &&
                       !(undo_mode && (step_ptr_reg == '0));
    assign load_ok   = int'(load_index) < MAX_STEPS;
    assign load_word = {DELAY_BITS'(load_delay), load_hdr};
    assign load_hit  = (cmd == CMD_LOAD) && load_ok && rd_ok &&
                       (int'(load_index) == int'(rd_ptr));

    // table address for the following beat, taken from the updated state
    assign undo_next   = (mode_next == M_ROLL) || (mode_next == M_DOWN) ||
                         (mode_next == M_ROLL_ACT) || (mode_next == M_DOWN_ACT);
    assign rd_ptr_next = !s_fire  ? rd_ptr :
                         undo_next ? (step_ptr_next - PW'(1)) : step_ptr_next;

    prs_step_table #(
        .DEPTH (MAX_STEPS),
        .WIDTH (STEP_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (s_fire && (cmd == CMD_LOAD) && load_ok),
        .wr_idx  (IW'(load_index)),
        .wr_data (load_word),
        .rd_idx  (rd_ptr_next[IW-1:0]),
        .rd_data (rd_raw)
    );

    // a load to the active step shows at once
    assign step_word = load_hit ? load_word : (rd_ok ? rd_raw : '0);

    step_hdr_t             st;
    logic [DELAY_BITS-1:0] st_delay;
    logic [N_ENABLES-1:0]  st_en_mask;
    logic                  en_bit_ok;
    logic                  sense_ok;

    assign st         = step_hdr_t'(step_word[HDR_W-1:0]);
    assign st_delay   = step_word[STEP_W-1:HDR_W];
    assign en_bit_ok  = int'(st.bit_idx) < N_ENABLES;
    assign st_en_mask = en_bit_ok ? (N_ENABLES'(1) << st.bit_idx) : '0;
    assign sense_ok   = (int'(st.bit_idx) < N_SENSES) && sense_bits[st.bit_idx];

    // next-state logic
    always_comb
    begin
        logic up_ok;
        mode_next     = mode_reg;
        step_ptr_next = step_ptr_reg;
        delay_next    = delay_reg;
        enable_next   = enable_reg;
        fault_next    = fault_reg;
        powered_next  = powered_reg;
        up_ok         = 1'b0;

        unique case (cmd)
            CMD_TICK:
            begin
                if (mode_reg == M_UP)
                begin
                    if (step_ptr_reg >= used_steps)
                    begin
                        powered_next = 1'b1;
                        mode_next    = M_IDLE;
                    end
                    else
                    begin
                        case (st.kind)
                            KIND_DRIVE:
                            begin
                                enable_next = enable_reg | st_en_mask;
                                up_ok       = 1'b1;
                            end
                            KIND_WAIT:   up_ok = sense_ok;
                            KIND_ACTION:
                            begin
                                if (st.on_action == '0)
                                    up_ok = 1'b1;
                                else
                                    mode_next = M_UP_ACT;
                            end
                            default:     up_ok = 1'b1;
                        endcase
                    end
                end
                else if (mode_reg == M_UP_DELAY)
                begin
                    if (delay_reg > DELAY_BITS'(1))
                    begin
                        delay_next = delay_reg - DELAY_BITS'(1);
                    end
                    else
                    begin
                        delay_next    = '0;
                        step_ptr_next = step_ptr_reg + PW'(1);
                        mode_next     = M_UP;
                    end
                end
                else if ((mode_reg == M_ROLL) || (mode_reg == M_DOWN))
                begin
                    if (step_ptr_reg == '0)
                    begin
                        mode_next = M_IDLE;
                    end
                    else if ((st.kind == KIND_ACTION) && (st.off_action != '0))
                    begin
                        mode_next = (mode_reg == M_ROLL) ? M_ROLL_ACT : M_DOWN_ACT;
                    end
                    else
                    begin
                        if (st.kind == KIND_DRIVE)
                            enable_next = enable_reg & ~st_en_mask;
                        step_ptr_next = step_ptr_reg - PW'(1);
                    end
                end
            end
            CMD_POWER_UP:
            begin
                if (mode_reg == M_IDLE)
                begin
                    step_ptr_next = '0;
                    delay_next    = '0;
                    fault_next    = 1'b0;
                    powered_next  = 1'b0;
                    mode_next     = M_UP;
                end
            end
            CMD_POWER_DOWN:
            begin
                if (mode_reg == M_IDLE)
                begin
                    step_ptr_next = used_steps;
                    powered_next  = 1'b0;
                    mode_next     = M_DOWN;
                end
            end
            CMD_ACT_DONE:
            begin
                if (mode_reg == M_UP_ACT)
                begin
                    if (action_failed)
                    begin
                        fault_next = 1'b1;
                        mode_next  = M_ROLL;
                    end
                    else
                    begin
                        up_ok = 1'b1;
                    end
                end
                else if ((mode_reg == M_ROLL_ACT) || (mode_reg == M_DOWN_ACT))
                begin
                    if (step_ptr_reg != '0)
                        step_ptr_next = step_ptr_reg - PW'(1);
                    mode_next = (mode_reg == M_ROLL_ACT) ? M_ROLL : M_DOWN;
                end
            end
            default:
            begin
                // load is handled by the table write; other codes do nothing
            end
        endcase

        // successful power-up step: start its delay or move on
        if (up_ok)
        begin
            if (st_delay != '0)
            begin
                delay_next = st_delay;
                mode_next  = M_UP_DELAY;
            end
            else
            begin
                step_ptr_next = step_ptr_reg + PW'(1);
                mode_next     = M_UP;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            step_ptr_reg <= '0;
            delay_reg    <= '0;
            enable_reg   <= '0;
            fault_reg    <= 1'b0;
            powered_reg  <= 1'b0;
        end
        else if (s_fire)
        begin
            mode_reg     <= mode_next;
            step_ptr_reg <= step_ptr_next;
            delay_reg    <= delay_next;
            enable_reg   <= enable_next;
            fault_reg    <= fault_next;
            powered_reg  <= powered_next;
        end
    end

    // result beat from the updated state
    result_t res_next;

    always_comb
    begin
        res_next               = '0;
        res_next.enable_bits   = ENOUT_W'(enable_next);
        res_next.busy_res      = (mode_next != M_IDLE);
        res_next.powered       = powered_next;
        res_next.fault         = fault_next;
        if (mode_next == M_UP_ACT)
        begin
            res_next.action_valid = 1'b1;
            res_next.action_code  = st.on_action;
        end
        else if (((mode_next == M_ROLL_ACT) || (mode_next == M_DOWN_ACT)) &&
                 (step_ptr_next != '0))
        begin
            res_next.action_valid  = 1'b1;
            res_next.action_code   = st.off_action;
            res_next.action_is_off = 1'b1;
        end
        if (undo_next && (step_ptr_next != '0))
            res_next.current_step = 6'(step_ptr_next - PW'(1));
        else if (undo_next)
            res_next.current_step = '0;
        else
            res_next.current_step = 6'(step_ptr_next);
    end

    prs_out_buf #(
        .WIDTH (RES_W)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_fire),
        .push_data  (res_next),
        .push_ready (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_data   (m_axis_tdata),
        .out_ready  (m_axis_tready)
    );

    // checks
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(step_ptr_reg) <= MAX_STEPS)
        else $error("step pointer beyond table depth");

    a_delay_live: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_UP_DELAY) |-> (delay_reg != '0))
        else $error("delay mode with zero delay left");

    a_start_up: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (cmd == CMD_POWER_UP) && (mode_reg == M_IDLE))
        |=> ((mode_reg == M_UP) && (step_ptr_reg == '0) && !fault_reg))
        else $error("power-up start did not begin at step zero");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

endmodule
